// File: hdl/srrw_pkg.sv
// ----------------------------------------------------------------------------
// Selective-repeat receive window: shared definitions
// Sizes, result codes, register indexes, the result record and the slot helper.
// ----------------------------------------------------------------------------
package srrw_pkg;

  localparam int WINDOW   = 32;
  localparam int SEQ_BITS = 16;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int HELD_W = $clog2(WINDOW + 1);

  localparam int SEQ_FIELD_W = 16;
  localparam int TICK_W      = 32;
  localparam int BITMAP_W    = 32;
  localparam int BM_IDX_W    = 5;
  localparam int SERIAL_W    = 16;
  localparam int DELAY_W     = 16;
  localparam int THR_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  typedef logic [SEQ_BITS-1:0] seq_t;
  typedef logic [SLOT_W-1:0]   slot_t;

  localparam seq_t SEQ_MASK = '1;

  typedef enum logic [2:0] {
    KIND_ACCEPTED = 3'd0,
    KIND_DROPPED  = 3'd1,
    KIND_RELEASED = 3'd2,
    KIND_ACK_SENT = 3'd3,
    KIND_NO_ACK   = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACK_DELAY = 2'd0,
    CFG_PEND_THR  = 2'd1
  } cfg_idx_t;

  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_POLL    = 1'b1;

  typedef struct packed {
    kind_t                 kind;
    logic [SEQ_FIELD_W-1:0] seq;
    logic [BITMAP_W-1:0]   bitmap;
    logic [SERIAL_W-1:0]   serial;
    logic                  last;
  } result_t;

  // Slot of the sequence number after q, given that s is the slot of q.
  // Sequence numbers wrap to zero, whose slot is zero.
  function automatic slot_t slot_inc(slot_t s, seq_t q);
    slot_t r;
    if (q == SEQ_MASK) begin
      r = '0;
    end else if (s == slot_t'(WINDOW - 1)) begin
      r = '0;
    end else begin
      r = s + slot_t'(1);
    end
    return r;
  endfunction

endpackage

// File: hdl/srrw_slot_ram.sv
// ----------------------------------------------------------------------------
// Slot number store
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module srrw_slot_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/srrw_out_reg.sv
// ----------------------------------------------------------------------------
// Result output register
// Holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module srrw_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  srrw_pkg::result_t res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output srrw_pkg::result_t out_res
);
  import srrw_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= res;
    end
  end

endmodule

// File: hdl/srrw_engine.sv
// ----------------------------------------------------------------------------
// Receive window engine
// Sequencer around the slot store: admission, in-order release, ack scan.
// ----------------------------------------------------------------------------
module srrw_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_opcode,
  input  logic [srrw_pkg::SEQ_FIELD_W-1:0]    in_seq_in,
  input  logic [srrw_pkg::TICK_W-1:0]         in_now_tick,
  input  logic [srrw_pkg::DELAY_W-1:0]        ack_delay,
  input  logic [srrw_pkg::THR_W-1:0]          pending_thr,
  input  logic                                emit_free,
  output logic                                push,
  output srrw_pkg::result_t                   res
);
  import srrw_pkg::*;

  localparam int SUM_W = SLOT_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_REL_RD, ST_REL_EMIT, ST_SCAN, ST_ACK_EMIT
  } state_t;

  state_t                state_r, state_nxt;
  logic                  op_r;
  seq_t                  seq_r;
  logic [TICK_W-1:0]     now_r;
  logic [WINDOW-1:0]     full_r, full_nxt;
  seq_t                  ne_r, ne_nxt;
  slot_t                 ne_slot_r, ne_slot_nxt;
  seq_t                  high_r, high_nxt;
  logic [HELD_W-1:0]     held_r, held_nxt;
  logic [TICK_W-1:0]     pend_r, pend_nxt;
  logic [TICK_W-1:0]     due_r, due_nxt;
  seq_t                  serial_r, serial_nxt;
  seq_t                  scan_seq_r, scan_seq_nxt;
  slot_t                 scan_slot_r, scan_slot_nxt;
  logic [CNT_W-1:0]      scan_i_r, scan_i_nxt;
  logic                  cmp_v_r, cmp_v_nxt;
  logic                  cmp_full_r, cmp_full_nxt;
  seq_t                  cmp_seq_r, cmp_seq_nxt;
  logic [BM_IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic [BITMAP_W-1:0]   bitmap_r, bitmap_nxt;

  logic                  ram_we, ram_re;
  slot_t                 ram_raddr;
  seq_t                  ram_q;

  seq_t                  diff;
  logic                  in_win;
  logic [SUM_W-1:0]      slot_sum, slot_red;
  slot_t                 arr_slot;
  slot_t                 rel_next;
  logic [TICK_W-1:0]     due_sum;
  logic                  ack_go;

  srrw_slot_ram #(.DEPTH(WINDOW), .WIDTH(SEQ_BITS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (arr_slot),
    .wdata (seq_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Slot of the arrival. Inside the window it follows from the base slot; a
  // number that wrapped past zero is below the window size and is its own slot.
  assign diff     = seq_r - ne_r;
  assign in_win   = diff < seq_t'(WINDOW);
  assign slot_sum = {1'b0, ne_slot_r} + SUM_W'(diff);
  assign slot_red = (slot_sum >= SUM_W'(WINDOW)) ? slot_sum - SUM_W'(WINDOW) : slot_sum;
  assign arr_slot = (seq_r < ne_r) ? slot_t'(seq_r) : slot_t'(slot_red);
  assign rel_next = slot_inc(ne_slot_r, ne_r);
  assign due_sum  = now_r + TICK_W'(ack_delay);
  assign ack_go   = (pend_r != '0) &&
                    ((pend_r > TICK_W'(pending_thr)) || (now_r >= due_r));
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    full_nxt      = full_r;
    ne_nxt        = ne_r;
    ne_slot_nxt   = ne_slot_r;
    high_nxt      = high_r;
    held_nxt      = held_r;
    pend_nxt      = pend_r;
    due_nxt       = due_r;
    serial_nxt    = serial_r;
    scan_seq_nxt  = scan_seq_r;
    scan_slot_nxt = scan_slot_r;
    scan_i_nxt    = scan_i_r;
    cmp_v_nxt     = 1'b0;
    cmp_full_nxt  = cmp_full_r;
    cmp_seq_nxt   = cmp_seq_r;
    cmp_idx_nxt   = cmp_idx_r;
    bitmap_nxt    = bitmap_r;
    push          = 1'b0;
    res           = '0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = ne_slot_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (op_r == OP_ARRIVAL) begin
          if (emit_free) begin
            push     = 1'b1;
            res.seq  = SEQ_FIELD_W'(seq_r);
            pend_nxt = (pend_r == '1) ? pend_r : pend_r + TICK_W'(1);
            due_nxt  = (due_r == '0) ? due_sum : due_r;
            if (!in_win || full_r[arr_slot]) begin
              res.kind  = KIND_DROPPED;
              res.last  = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              full_nxt[arr_slot] = 1'b1;
              ram_we             = 1'b1;
              held_nxt           = held_r + HELD_W'(1);
              res.kind           = KIND_ACCEPTED;
              res.last           = (seq_r != ne_r);
              state_nxt          = (seq_r == ne_r) ? ST_REL_RD : ST_IDLE;
              if (seq_r > high_r) begin
                due_nxt = '0;
              end
              if (seq_r >= high_r) begin
                high_nxt = seq_r + seq_t'(1);
              end
            end
          end
        end else if (ack_go) begin
          scan_seq_nxt  = ne_r;
          scan_slot_nxt = ne_slot_r;
          scan_i_nxt    = '0;
          bitmap_nxt    = '0;
          state_nxt     = ST_SCAN;
        end else if (emit_free) begin
          push      = 1'b1;
          res.kind  = KIND_NO_ACK;
          res.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_REL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ne_slot_r;
        state_nxt = ST_REL_EMIT;
      end

      ST_REL_EMIT: begin
        if (emit_free) begin
          push                = 1'b1;
          res.kind            = KIND_RELEASED;
          res.seq             = SEQ_FIELD_W'(ram_q);
          full_nxt[ne_slot_r] = 1'b0;
          if (held_r != '0) begin
            held_nxt = held_r - HELD_W'(1);
          end
          ne_nxt      = ne_r + seq_t'(1);
          ne_slot_nxt = rel_next;
          // The slot just freed ends the run if the next one maps onto it.
          if (full_r[rel_next] && (rel_next != ne_slot_r)) begin
            ram_re    = 1'b1;
            ram_raddr = rel_next;
          end else begin
            res.last  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_SCAN: begin
        if (scan_i_r != CNT_W'(WINDOW)) begin
          ram_re        = 1'b1;
          ram_raddr     = scan_slot_r;
          cmp_v_nxt     = 1'b1;
          cmp_full_nxt  = full_r[scan_slot_r];
          cmp_seq_nxt   = scan_seq_r;
          cmp_idx_nxt   = BM_IDX_W'(scan_i_r);
          scan_i_nxt    = scan_i_r + CNT_W'(1);
          scan_seq_nxt  = scan_seq_r + seq_t'(1);
          scan_slot_nxt = slot_inc(scan_slot_r, scan_seq_r);
        end else if (!cmp_v_r) begin
          state_nxt = ST_ACK_EMIT;
        end
        if (cmp_v_r && cmp_full_r && (ram_q == cmp_seq_r)) begin
          bitmap_nxt[cmp_idx_r] = 1'b1;
        end
      end

      ST_ACK_EMIT: begin
        if (emit_free) begin
          push       = 1'b1;
          res.kind   = KIND_ACK_SENT;
          res.seq    = SEQ_FIELD_W'(ne_r);
          res.bitmap = bitmap_r;
          res.serial = SERIAL_W'(serial_r);
          res.last   = 1'b1;
          serial_nxt = serial_r + seq_t'(1);
          if (held_r != '0) begin
            pend_nxt = TICK_W'(1);
            due_nxt  = due_sum;
          end else begin
            pend_nxt = '0;
            due_nxt  = '0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      full_r    <= '0;
      ne_r      <= '0;
      ne_slot_r <= '0;
      high_r    <= '0;
      held_r    <= '0;
      pend_r    <= '0;
      due_r     <= '0;
      serial_r  <= '0;
      cmp_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      full_r    <= full_nxt;
      ne_r      <= ne_nxt;
      ne_slot_r <= ne_slot_nxt;
      high_r    <= high_nxt;
      held_r    <= held_nxt;
      pend_r    <= pend_nxt;
      due_r     <= due_nxt;
      serial_r  <= serial_nxt;
      cmp_v_r   <= cmp_v_nxt;
    end
    if (state_r == ST_IDLE && in_valid) begin
      op_r  <= in_opcode;
      seq_r <= seq_t'(in_seq_in);
      now_r <= in_now_tick;
    end
    scan_seq_r  <= scan_seq_nxt;
    scan_slot_r <= scan_slot_nxt;
    scan_i_r    <= scan_i_nxt;
    cmp_full_r  <= cmp_full_nxt;
    cmp_seq_r   <= cmp_seq_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    bitmap_r    <= bitmap_nxt;
  end

  // The held count always agrees with the occupancy flags.
  a_held_matches_full: assert property (@(posedge clk) disable iff (!rst_n)
    held_r == HELD_W'($countones(full_r)))
    else $error("held count differs from occupied slots");

  // A release only ever comes from an occupied slot.
  a_release_from_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REL_EMIT) |-> full_r[ne_slot_r])
    else $error("release from an empty slot");

  // The slot store is never written while a scan or release is reading it.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_REL_EMIT || state_r == ST_REL_RD) |-> !ram_we)
    else $error("slot store written during a read sequence");

  // After an acknowledgement at most one arrival is counted as pending.
  a_pending_after_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACK_EMIT && emit_free) |=> (pend_r <= TICK_W'(1)))
    else $error("pending count not reset by acknowledgement");

endmodule

// File: hdl/selective_repeat_receive_window_unit.sv
// ----------------------------------------------------------------------------
// Selective-repeat receive window unit
// Receive side of a selective-repeat protocol for one peer, with ack pacing.
// ----------------------------------------------------------------------------
// Usage. Items enter on the in_ channel: opcode 0 is a datagram arrival with
// its sequence number, opcode 1 is an acknowledgement poll; both carry the
// current tick. Each item produces one or more result transactions on the
// out_ channel, the final one flagged by out_last. Registers are written on
// the cfg_ channel, which is always ready; the user must write them only
// while the unit is idle, since the unit itself does not enforce this.
// An accepted in-order arrival reads the slot store and then releases the
// numbers one by one. A poll that sends an ack reads each of the WINDOW
// slots once through the single read port.
// The unit works on one item at a time; in_stall is high from the cycle
// after acceptance until the last result has been handed to the output
// register, which lets the next item in while that result still waits.
// Reset (rst_n low, synchronous) empties every slot at once, clears all
// counters and loads ack_delay = 100 and pending_threshold = 16.
// While out_stall is high a held result stays put, and the engine waits
// whenever it has another result to push.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_opcode,
  input  logic [srrw_pkg::SEQ_FIELD_W-1:0]     in_seq_in,
  input  logic [srrw_pkg::TICK_W-1:0]          in_now_tick,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [2:0]                           out_kind,
  output logic [srrw_pkg::SEQ_FIELD_W-1:0]     out_seq_out,
  output logic [srrw_pkg::BITMAP_W-1:0]        out_ack_bitmap,
  output logic [srrw_pkg::SERIAL_W-1:0]        out_ack_serial,
  output logic                                 out_last,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [srrw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [srrw_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import srrw_pkg::*;

  logic [DELAY_W-1:0] ack_delay_r;
  logic [THR_W-1:0]   pend_thr_r;
  logic               emit_free;
  logic               push;
  result_t            res;
  result_t            out_res;

  // Configuration registers; writes to unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_delay_r <= DELAY_W'(100);
      pend_thr_r  <= THR_W'(16);
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ACK_DELAY: ack_delay_r <= DELAY_W'(cfg_data);
        CFG_PEND_THR:  pend_thr_r  <= THR_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  srrw_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_opcode   (in_opcode),
    .in_seq_in   (in_seq_in),
    .in_now_tick (in_now_tick),
    .ack_delay   (ack_delay_r),
    .pending_thr (pend_thr_r),
    .emit_free   (emit_free),
    .push        (push),
    .res         (res)
  );

  srrw_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res       (res),
    .free      (emit_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind       = out_res.kind;
  assign out_seq_out    = out_res.seq;
  assign out_ack_bitmap = out_res.bitmap;
  assign out_ack_serial = out_res.serial;
  assign out_last       = out_res.last;

endmodule
